[hdl/tlmc_pkg.sv]
// shared types and constants for the traffic light mode controller
// request payload structs, register map and register reset values; no dependencies
package tlmc_pkg;

  localparam int unsigned REG_WIDTH  = 14;
  localparam int unsigned ADDR_WIDTH = 4;
  localparam int unsigned DATA_WIDTH = 32;

  // register indexes, byte address is 4 * index
  localparam logic [1:0] REG_RED    = 2'd0;
  localparam logic [1:0] REG_YELLOW = 2'd1;
  localparam logic [1:0] REG_GREEN  = 2'd2;

  localparam logic [REG_WIDTH-1:0] RED_TICKS_RST    = REG_WIDTH'(3000);
  localparam logic [REG_WIDTH-1:0] YELLOW_TICKS_RST = REG_WIDTH'(500);
  localparam logic [REG_WIDTH-1:0] GREEN_TICKS_RST  = REG_WIDTH'(2000);

  typedef struct packed {
    logic mode_press;
    logic speed_press;
  } tlmc_in_t;

  typedef struct packed {
    logic red_lamp;
    logic yellow_lamp;
    logic green_lamp;
  } tlmc_out_t;

  typedef struct packed {
    logic [REG_WIDTH-1:0] red_ticks;
    logic [REG_WIDTH-1:0] yellow_ticks;
    logic [REG_WIDTH-1:0] green_ticks;
  } tlmc_cfg_t;

endpackage

[hdl/traffic_light_mode_controller.sv]
// traffic light mode controller: one tick request in, one lamp request out
// lamps for a tick appear from the output register in the cycle after the tick is accepted
// throughput: one tick per cycle while the output is not stalled, with a single state update stage
// reset: durations 3000/500/2000, normal mode on red, normal speed, lamps dark, output empty
// depends on tlmc_pkg and tlmc_regs
module traffic_light_mode_controller #(
  parameter int unsigned TIME_WIDTH = 15
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  tlmc_pkg::tlmc_in_t              in_data_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output tlmc_pkg::tlmc_out_t             out_data_o,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [tlmc_pkg::ADDR_WIDTH-1:0] paddr,
  input  logic [tlmc_pkg::DATA_WIDTH-1:0] pwdata,
  output logic [tlmc_pkg::DATA_WIDTH-1:0] prdata,
  output logic                            pready
);
  import tlmc_pkg::*;

  typedef enum logic [1:0] {
    MODE_NORMAL = 2'd0,
    MODE_OFF    = 2'd1,
    MODE_ALARM  = 2'd2
  } mode_e;

  typedef enum logic [1:0] {
    SPEED_NORMAL = 2'd0,
    SPEED_FAST   = 2'd1,
    SPEED_SLOW   = 2'd2
  } speed_e;

  typedef enum logic [1:0] {
    COL_RED    = 2'd0,
    COL_YELLOW = 2'd1,
    COL_GREEN  = 2'd2
  } colour_e;

  typedef logic [TIME_WIDTH-1:0] time_t;

  tlmc_cfg_t cfg;

  tlmc_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  mode_e     mode_q, mode_d;
  speed_e    speed_q, speed_d;
  speed_e    scale_q, scale_d;
  colour_e   colour_q, colour_d;
  colour_e   prev_q, prev_d;
  time_t     phase_q, phase_d;
  time_t     ycnt_q, ycnt_d;
  time_t     rcnt_q, rcnt_d;
  logic      ylvl_q, ylvl_d;
  logic      rlvl_q, rlvl_d;
  logic      out_valid_q;
  tlmc_out_t out_q, out_d;
  logic      accept;

  function automatic time_t scaled(input logic [REG_WIDTH-1:0] base, input speed_e sc);
    logic [REG_WIDTH:0] b;
    b = {1'b0, base};
    unique case (sc)
      SPEED_FAST: b = b >> 1;
      SPEED_SLOW: b = b << 1;
      default:    b = b;
    endcase
    return TIME_WIDTH'(b);
  endfunction

  assign in_stall_o  = out_valid_q && out_stall_i;
  assign accept      = in_valid_i && !in_stall_o;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  always_comb begin
    mode_d   = mode_q;
    speed_d  = speed_q;
    scale_d  = scale_q;
    colour_d = colour_q;
    prev_d   = prev_q;
    phase_d  = phase_q;
    ycnt_d   = ycnt_q;
    rcnt_d   = rcnt_q;
    ylvl_d   = ylvl_q;
    rlvl_d   = rlvl_q;
    out_d    = out_q;

    // time base moves before the lamps; a speed press keeps the applied scale
    if (in_data_i.speed_press) begin
      unique case (speed_q)
        SPEED_NORMAL: speed_d = SPEED_FAST;
        SPEED_FAST:   speed_d = SPEED_SLOW;
        default:      speed_d = SPEED_NORMAL;
      endcase
    end else begin
      scale_d = speed_q;
    end

    if (in_data_i.mode_press) begin
      unique case (mode_q)
        MODE_NORMAL: mode_d = MODE_OFF;
        MODE_OFF:    mode_d = MODE_ALARM;
        default:     mode_d = MODE_NORMAL;
      endcase
      out_d = '0;
    end

    unique case (mode_d)
      MODE_NORMAL: begin
        unique case (colour_q)
          COL_RED:    out_d.red_lamp    = 1'b1;
          COL_YELLOW: out_d.yellow_lamp = 1'b1;
          default:    out_d.green_lamp  = 1'b1;
        endcase
        if (prev_q != colour_q) begin
          unique case (colour_q)
            COL_YELLOW: phase_d = scaled(cfg.yellow_ticks, scale_d);
            COL_GREEN:  phase_d = scaled(cfg.green_ticks, scale_d);
            default:    phase_d = scaled(cfg.red_ticks, scale_d);
          endcase
        end
        phase_d = phase_d - time_t'(1);
        prev_d  = colour_q;
        // dark tick at each colour change
        if (phase_d == '0) begin
          unique case (colour_q)
            COL_RED:    colour_d = COL_GREEN;
            COL_YELLOW: colour_d = COL_RED;
            default:    colour_d = COL_YELLOW;
          endcase
          out_d = '0;
        end
      end
      MODE_OFF: begin
        ycnt_d = ycnt_q - time_t'(1);
        if (ycnt_d == '0) begin
          ylvl_d = !ylvl_q;
          ycnt_d = scaled(cfg.yellow_ticks, scale_d);
        end
        out_d.yellow_lamp = ylvl_d;
      end
      default: begin
        rcnt_d = rcnt_q - time_t'(1);
        if (rcnt_d == '0) begin
          rlvl_d = !rlvl_q;
          rcnt_d = scaled(cfg.green_ticks, scale_d);
        end
        out_d.red_lamp = rlvl_d;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q      <= MODE_NORMAL;
      speed_q     <= SPEED_NORMAL;
      scale_q     <= SPEED_NORMAL;
      colour_q    <= COL_RED;
      prev_q      <= COL_RED;
      phase_q     <= TIME_WIDTH'(3000);
      ycnt_q      <= TIME_WIDTH'(500);
      rcnt_q      <= TIME_WIDTH'(2000);
      ylvl_q      <= 1'b1;
      rlvl_q      <= 1'b1;
      out_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        mode_q   <= mode_d;
        speed_q  <= speed_d;
        scale_q  <= scale_d;
        colour_q <= colour_d;
        prev_q   <= prev_d;
        phase_q  <= phase_d;
        ycnt_q   <= ycnt_d;
        rcnt_q   <= rcnt_d;
        ylvl_q   <= ylvl_d;
        rlvl_q   <= rlvl_d;
        out_q    <= out_d;
      end
      // output register doubles as the lamp state
      if (accept) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

endmodule

[hdl/tlmc_regs.sv]
// apb register block holding the three base durations
// depends on tlmc_pkg for the register map and the config struct
module tlmc_regs (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [tlmc_pkg::ADDR_WIDTH-1:0] paddr,
  input  logic [tlmc_pkg::DATA_WIDTH-1:0] pwdata,
  output logic [tlmc_pkg::DATA_WIDTH-1:0] prdata,
  output logic                            pready,
  output tlmc_pkg::tlmc_cfg_t             cfg_o
);
  import tlmc_pkg::*;

  tlmc_cfg_t  cfg_q;
  logic [1:0] reg_idx;
  logic       wr_en;

  assign reg_idx = paddr[3:2];
  assign wr_en   = psel && penable && pwrite;
  assign pready  = 1'b1;
  assign cfg_o   = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.red_ticks    <= RED_TICKS_RST;
      cfg_q.yellow_ticks <= YELLOW_TICKS_RST;
      cfg_q.green_ticks  <= GREEN_TICKS_RST;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_RED:    cfg_q.red_ticks    <= pwdata[REG_WIDTH-1:0];
        REG_YELLOW: cfg_q.yellow_ticks <= pwdata[REG_WIDTH-1:0];
        REG_GREEN:  cfg_q.green_ticks  <= pwdata[REG_WIDTH-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_RED:    prdata = DATA_WIDTH'(cfg_q.red_ticks);
      REG_YELLOW: prdata = DATA_WIDTH'(cfg_q.yellow_ticks);
      REG_GREEN:  prdata = DATA_WIDTH'(cfg_q.green_ticks);
      default:    prdata = '0;
    endcase
  end

endmodule

[hdl/tlmc_checker.sv]
// port-level checks for the traffic light mode controller, bound to the top level
// depends on tlmc_pkg for the payload structs
module tlmc_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_stall_o,
  input logic                out_valid_o,
  input logic                out_stall_i,
  input tlmc_pkg::tlmc_out_t out_data_o,
  input logic                pready
);
  import tlmc_pkg::*;

  // a held result stays offered
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result dropped while stalled");

  // every accepted tick yields a result in the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> out_valid_o)
    else $error("accepted tick gave no result");

  // input is only held back by a waiting result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> !in_stall_o)
    else $error("input stalled with empty output");

  // no mode ever lights two lamps together
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> $countones({out_data_o.red_lamp, out_data_o.yellow_lamp,
                                out_data_o.green_lamp}) <= 1)
    else $error("more than one lamp lit");

  assert property (@(posedge clk_i) disable iff (!rst_ni) pready)
    else $error("pready low");

endmodule

bind traffic_light_mode_controller tlmc_checker u_tlmc_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_o  (out_data_o),
  .pready      (pready)
);
